FILE: hdl/ffrp_pkg.sv
package ffrp_pkg;

  localparam int MAP_DEPTH = 1024;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Run counter holds up to MAP_DEPTH + 1, target up to two 15-bit lengths summed
  localparam int RUN_W     = 17;
  // Low block bits that survive the shift by 5 into a 16-bit unit value
  localparam int BLK_LO_W  = 11;
  localparam int UNIT_SH   = 5;

  localparam int NUM_REGS  = 3;
  localparam int PADDR_W   = 4;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_LIMIT = 2'd1,
    REG_BIAS  = 2'd2
  } reg_idx_t;

  localparam logic [2:0] STAT_PLACED  = 3'd0;
  localparam logic [2:0] STAT_NOFIT   = 3'd1;
  localparam logic [2:0] STAT_BADLEN  = 3'd2;
  localparam logic [2:0] STAT_FAULT   = 3'd3;
  localparam logic [2:0] STAT_WRITTEN = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef logic [MAP_AW-1:0] map_addr_t;

  typedef struct packed {
    logic signed [31:0] start_blk;
    logic signed [31:0] limit_blk;
    logic signed [31:0] scan_blk;
  } cfg_t;

  typedef struct packed {
    logic      en;
    map_addr_t addr;
    logic      data;
  } map_wr_t;

  typedef struct packed {
    logic      en;
    map_addr_t addr;
  } map_rd_t;

  // Signed divide by 32, truncating toward zero
  function automatic logic signed [31:0] div32(input logic signed [31:0] x);
    logic signed [31:0] adj;
    adj = x[31] ? (x + 32'sd31) : x;
    return adj >>> UNIT_SH;
  endfunction

  function automatic logic [15:0] to_units(input logic [BLK_LO_W-1:0] blk);
    return {blk, {UNIT_SH{1'b0}}};
  endfunction

endpackage

FILE: hdl/ffrp_map_ram.sv
module ffrp_map_ram (
  input  logic              clk,
  input  ffrp_pkg::map_wr_t wr,
  input  ffrp_pkg::map_rd_t rd,
  output logic              rd_data
);

  logic mem [ffrp_pkg::MAP_DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ffrp_cfg.sv
module ffrp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffrp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ffrp_pkg::cfg_t                cfg
);

  logic signed [31:0] base_r;
  logic signed [31:0] limit_r;
  logic [15:0]        bias_r;
  logic               wr_en;
  logic [1:0]         reg_sel;
  logic signed [31:0] delta;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= '0;
      bias_r  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        ffrp_pkg::REG_BASE:  base_r  <= pwdata;
        ffrp_pkg::REG_LIMIT: limit_r <= pwdata;
        ffrp_pkg::REG_BIAS:  bias_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ffrp_pkg::REG_BASE:  prdata = base_r;
      ffrp_pkg::REG_LIMIT: prdata = limit_r;
      ffrp_pkg::REG_BIAS:  prdata = {16'd0, bias_r};
      default:             prdata = '0;
    endcase
  end

  assign delta         = base_r - $signed({16'd0, bias_r});
  assign cfg.start_blk = ffrp_pkg::div32(base_r);
  assign cfg.limit_blk = ffrp_pkg::div32(limit_r);
  assign cfg.scan_blk  = ffrp_pkg::div32(delta);

endmodule

FILE: hdl/ffrp_ctrl.sv
module ffrp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffrp_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [9:0]           in_map_index,
  input  logic                 in_map_busy,
  input  logic signed [15:0]   in_record_level,
  input  logic [15:0]          in_record_flag_a,
  input  logic [15:0]          in_record_flag_b,
  input  logic signed [15:0]   in_stored_image_length,
  input  logic signed [15:0]   in_stored_palette_length,
  input  logic                 in_keep_lengths,
  input  logic signed [31:0]   in_wanted_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [15:0]          out_image_start,
  output logic [15:0]          out_palette_start,
  output logic                 out_palette_start_valid,
  output logic                 out_lengths_forced,
  output logic                 out_palette_forced,
  output ffrp_pkg::map_wr_t    map_wr,
  output ffrp_pkg::map_rd_t    map_rd,
  input  logic                 map_rd_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_READ  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam int BW = ffrp_pkg::BLK_LO_W;
  localparam int RW = ffrp_pkg::RUN_W;

  state_t                   state_r;
  ffrp_pkg::map_addr_t      clr_addr_r;

  logic signed [31:0]       cursor_r;
  logic signed [31:0]       start_r;
  logic signed [31:0]       cand_r;
  logic signed [31:0]       want_r;
  logic [RW-1:0]            run_r;
  logic [RW-1:0]            target_r;
  logic signed [15:0]       img_r;
  logic signed [15:0]       pal_r;
  logic [15:0]              left_r;
  logic                     fixed_r;
  logic                     skip_r;
  logic                     fbz_r;

  logic [2:0]               res_status_r;
  logic [15:0]              res_istart_r;
  logic [15:0]              res_pstart_r;
  logic                     res_pvalid_r;
  logic                     res_forced_r;
  logic                     res_pforced_r;

  logic                     out_valid_r;
  logic [2:0]               out_status_r;
  logic [15:0]              out_istart_r;
  logic [15:0]              out_pstart_r;
  logic                     out_pvalid_r;
  logic                     out_forced_r;
  logic                     out_pforced_r;

  logic                     accept;
  logic                     palette_ok;
  logic                     fb_zero;
  logic                     cur_in_map;
  logic [RW-1:0]            run_inc;
  logic signed [31:0]       cand_inc;
  logic [BW-1:0]            chosen_lo;
  logic                     out_load;
  logic                     wr_in_map;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_stall   = (state_r != S_IDLE);
  assign fb_zero    = (in_record_flag_b == 16'd0);
  assign palette_ok = !in_record_level[15] && (in_record_flag_a == 16'd0) && fb_zero;
  assign cur_in_map = (cursor_r >= 0) && (cursor_r < ffrp_pkg::MAP_DEPTH);
  assign run_inc    = run_r + RW'(1);
  assign cand_inc   = cand_r + 32'sd1;
  assign chosen_lo  = start_r[BW-1:0] + want_r[BW-1:0];
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign wr_in_map  = ({7'd0, in_map_index} < 17'(ffrp_pkg::MAP_DEPTH));

  // Map write port: clearing sweep after reset, otherwise write beats
  always_comb begin
    if (state_r == S_CLEAR) begin
      map_wr.en   = 1'b1;
      map_wr.addr = clr_addr_r;
      map_wr.data = 1'b0;
    end else begin
      map_wr.en   = accept && (in_operation == ffrp_pkg::OP_WRITE) && wr_in_map;
      map_wr.addr = ffrp_pkg::map_addr_t'(in_map_index);
      map_wr.data = in_map_busy;
    end
  end

  assign map_rd.en   = (state_r == S_READ) && cur_in_map;
  assign map_rd.addr = ffrp_pkg::map_addr_t'(cursor_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ffrp_pkg::map_addr_t'(1);
          if (clr_addr_r == ffrp_pkg::map_addr_t'(ffrp_pkg::MAP_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= (in_operation == ffrp_pkg::OP_WRITE) ? S_DONE : S_CHECK;
          end
        end
        S_CHECK: begin
          if (img_r <= 16'sd0 || (want_r == 32'sd0 && pal_r < 16'sd0)) begin
            state_r <= S_DONE;
          end else if (want_r != 32'sd0 && want_r < cfg.start_blk &&
                       want_r >= cfg.limit_blk) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= cur_in_map ? S_EVAL : S_DONE;
        end
        S_EVAL: begin
          if (fixed_r) begin
            state_r <= (map_rd_data || left_r == 16'd1) ? S_DONE : S_READ;
          end else if (map_rd_data) begin
            state_r <= S_STEP;
          end else if (!skip_r && run_inc == target_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_READ;
          end
        end
        S_STEP: begin
          state_r <= (cand_inc >= cfg.limit_blk) ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_istart_r <= '0;
          res_pstart_r <= '0;
          res_pvalid_r <= 1'b0;
          if (in_operation == ffrp_pkg::OP_WRITE) begin
            res_status_r  <= ffrp_pkg::STAT_WRITTEN;
            res_forced_r  <= 1'b0;
            res_pforced_r <= 1'b0;
          end else begin
            res_status_r <= ffrp_pkg::STAT_PLACED;
            fbz_r        <= fb_zero;
            want_r       <= in_wanted_index;
            if (!in_keep_lengths) begin
              img_r         <= 16'sd1;
              pal_r         <= palette_ok ? 16'sd1 : 16'sd0;
              res_forced_r  <= 1'b1;
              res_pforced_r <= palette_ok;
            end else begin
              img_r         <= in_stored_image_length;
              pal_r         <= palette_ok ? in_stored_palette_length : 16'sd0;
              res_forced_r  <= 1'b0;
              res_pforced_r <= 1'b0;
            end
          end
        end
      end
      S_CHECK: begin
        start_r  <= cfg.start_blk;
        run_r    <= '0;
        skip_r   <= 1'b0;
        left_r   <= img_r;
        target_r <= RW'(img_r) + RW'(pal_r);
        if (img_r <= 16'sd0 || (want_r == 32'sd0 && pal_r < 16'sd0)) begin
          res_status_r <= ffrp_pkg::STAT_BADLEN;
        end else if (want_r == 32'sd0) begin
          cursor_r <= cfg.scan_blk;
          fixed_r  <= 1'b0;
        end else if (want_r < cfg.start_blk && want_r >= cfg.limit_blk) begin
          res_status_r <= ffrp_pkg::STAT_NOFIT;
        end else begin
          cursor_r <= want_r;
          fixed_r  <= 1'b1;
        end
      end
      S_READ: begin
        if (!cur_in_map) begin
          res_status_r <= ffrp_pkg::STAT_FAULT;
        end
      end
      S_EVAL: begin
        if (fixed_r) begin
          if (map_rd_data) begin
            res_status_r <= ffrp_pkg::STAT_NOFIT;
          end else begin
            cursor_r <= cursor_r + 32'sd1;
            left_r   <= left_r - 16'd1;
            if (left_r == 16'd1) begin
              res_istart_r <= ffrp_pkg::to_units(chosen_lo);
              res_pstart_r <= ffrp_pkg::to_units(chosen_lo + img_r[BW-1:0]);
              res_pvalid_r <= 1'b1;
            end
          end
        end else if (map_rd_data) begin
          // Occupied entry on the free scan: open a skip over the busy run
          if (!skip_r) begin
            cand_r <= start_r + $signed({{(32-RW){1'b0}}, run_r});
          end
        end else if (skip_r) begin
          // End of a busy run: rebase and reread this entry as a free one
          start_r <= start_r + $signed({{(32-RW){1'b0}}, run_r});
          run_r   <= '0;
          skip_r  <= 1'b0;
        end else begin
          cursor_r <= cursor_r + 32'sd1;
          run_r    <= run_inc;
          if (run_inc == target_r) begin
            res_istart_r <= ffrp_pkg::to_units(start_r[BW-1:0]);
            if (fbz_r) begin
              res_pstart_r <= ffrp_pkg::to_units(start_r[BW-1:0] + img_r[BW-1:0]);
              res_pvalid_r <= 1'b1;
            end
          end
        end
      end
      S_STEP: begin
        cursor_r <= cursor_r + 32'sd1;
        run_r    <= run_inc;
        cand_r   <= cand_inc;
        skip_r   <= 1'b1;
        if (cand_inc >= cfg.limit_blk) begin
          res_status_r <= ffrp_pkg::STAT_NOFIT;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the beat while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_istart_r  <= res_istart_r;
      out_pstart_r  <= res_pstart_r;
      out_pvalid_r  <= res_pvalid_r;
      out_forced_r  <= res_forced_r;
      out_pforced_r <= res_pforced_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_image_start         = out_istart_r;
  assign out_palette_start       = out_pstart_r;
  assign out_palette_start_valid = out_pvalid_r;
  assign out_lengths_forced      = out_forced_r;
  assign out_palette_forced      = out_pforced_r;

endmodule

FILE: hdl/first_fit_run_placement_top.sv
// First-fit run placement over a one-bit-per-block occupancy map.
// Input channel (in_valid / in_stall): one beat is one item. Operation 0
// writes one map entry; operation 1 places a record, either by a first-fit
// search from the scan start block or by checking a fixed run at
// in_wanted_index. Every item gives exactly one result beat on the output
// channel (out_valid / out_stall).
// Steps: a map write is passed straight to the result register. A placement
// passes a check state, then visits map entries, each with one synchronous
// read and one evaluate; a busy entry adds a step state, and the free entry
// that ends a busy run is read and evaluated again; a fixed check visits at
// most the image length in entries.
// Items are taken one at a time: in_stall is high while an item is in work,
// and the next item is taken the cycle after its result is loaded.
// The output register holds a finished beat while out_stall is high; the
// block still accepts and works the next item, then waits to hand it over.
// After reset the map is cleared one entry a cycle, all MAP_DEPTH (1024) entries,
// with in_stall high; the APB register port is usable throughout and
// registers reset to zero.
module first_fit_run_placement_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffrp_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [9:0]                          in_map_index,
  input  logic                                in_map_busy,
  input  logic signed [15:0]                  in_record_level,
  input  logic [15:0]                         in_record_flag_a,
  input  logic [15:0]                         in_record_flag_b,
  input  logic signed [15:0]                  in_stored_image_length,
  input  logic signed [15:0]                  in_stored_palette_length,
  input  logic                                in_keep_lengths,
  input  logic signed [31:0]                  in_wanted_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [15:0]                         out_image_start,
  output logic [15:0]                         out_palette_start,
  output logic                                out_palette_start_valid,
  output logic                                out_lengths_forced,
  output logic                                out_palette_forced
);

  ffrp_pkg::cfg_t    cfg;
  ffrp_pkg::map_wr_t map_wr;
  ffrp_pkg::map_rd_t map_rd;
  logic              map_rd_data;

  ffrp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffrp_map_ram u_map (
    .clk     (clk),
    .wr      (map_wr),
    .rd      (map_rd),
    .rd_data (map_rd_data)
  );

  ffrp_ctrl u_ctrl (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg                      (cfg),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_operation             (in_operation),
    .in_map_index             (in_map_index),
    .in_map_busy              (in_map_busy),
    .in_record_level          (in_record_level),
    .in_record_flag_a         (in_record_flag_a),
    .in_record_flag_b         (in_record_flag_b),
    .in_stored_image_length   (in_stored_image_length),
    .in_stored_palette_length (in_stored_palette_length),
    .in_keep_lengths          (in_keep_lengths),
    .in_wanted_index          (in_wanted_index),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status               (out_status),
    .out_image_start          (out_image_start),
    .out_palette_start        (out_palette_start),
    .out_palette_start_valid  (out_palette_start_valid),
    .out_lengths_forced       (out_lengths_forced),
    .out_palette_forced       (out_palette_forced),
    .map_wr                   (map_wr),
    .map_rd                   (map_rd),
    .map_rd_data              (map_rd_data)
  );

endmodule

FILE: hdl/ffrp_checker.sv
module ffrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [15:0] out_image_start,
  input logic [15:0] out_palette_start,
  input logic        out_palette_start_valid,
  input logic        out_lengths_forced,
  input logic        out_palette_forced
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_image_start) && $stable(out_palette_start))
    else $error("stalled result beat changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffrp_pkg::STAT_PLACED |->
      out_image_start == 16'd0 && out_palette_start == 16'd0 && !out_palette_start_valid)
    else $error("start fields set on an unplaced result");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ffrp_pkg::STAT_WRITTEN |->
      !out_lengths_forced && !out_palette_forced)
    else $error("forced flags on a map write result");

  a_pforce_impl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_palette_forced |-> out_lengths_forced)
    else $error("palette forced without image forced");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ffrp_pkg::STAT_PLACED || out_status == ffrp_pkg::STAT_NOFIT ||
      out_status == ffrp_pkg::STAT_BADLEN || out_status == ffrp_pkg::STAT_FAULT ||
      out_status == ffrp_pkg::STAT_WRITTEN)
    else $error("result status out of range");

endmodule

bind first_fit_run_placement_top ffrp_checker u_ffrp_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_status              (out_status),
  .out_image_start         (out_image_start),
  .out_palette_start       (out_palette_start),
  .out_palette_start_valid (out_palette_start_valid),
  .out_lengths_forced      (out_lengths_forced),
  .out_palette_forced      (out_palette_forced)
);
